### hdl/touch_report_tracker_unit_assert.svh
// ----------------------------------------------------------------------------
// Touch report tracker assertion macros
// Concurrent check helpers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TOUCH_REPORT_TRACKER_UNIT_ASSERT_SVH
`define TOUCH_REPORT_TRACKER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TRK_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("touch tracker check failed");
`define TRK_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("touch tracker check failed");
`else
`define TRK_ASSERT_NOW(label, clk, rst, pre, post)
`define TRK_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

### hdl/trk_pkg.sv
// ----------------------------------------------------------------------------
// Touch report tracker package
// Shared types and constants of the tracker lanes, merge stage and top level.
// ----------------------------------------------------------------------------
package trk_pkg;

   localparam int SLOTS      = 5;
   localparam int MAX_POINTS = 5;

   localparam logic [7:0]  WRAP_LIMIT  = 8'd240;
   localparam logic [7:0]  FLAG_DOWN   = 8'h80;
   localparam logic [7:0]  FLAG_CAUGHT = 8'h40;
   localparam logic [7:0]  MASK_KEEP   = 8'hE0;
   localparam logic [15:0] COORD_NONE  = 16'hFFFF;

   localparam logic [15:0] WIDTH_RESET  = 16'd240;
   localparam logic [15:0] HEIGHT_RESET = 16'd320;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ORIENT = 2'd2;

   typedef enum logic [1:0] {
      ORIENT_DIRECT  = 2'd0,
      ORIENT_MIRROR  = 2'd1,
      ORIENT_SWAP_YM = 2'd2,
      ORIENT_SWAP_XM = 2'd3
   } orient_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
   } point_type;

   typedef struct packed {
      logic [7:0] mask;
      logic       clear_req;
      logic       restart;
   } merge_ctl_type;

endpackage

### hdl/trk_lane.sv
// ----------------------------------------------------------------------------
// Touch report tracker lane
// Maps the raw word pair of one point into screen coordinates.
// ----------------------------------------------------------------------------
module trk_lane (
   input  logic [15:0]          first_word,
   input  logic [15:0]          second_word,
   input  trk_pkg::orient_type  orientation,
   input  logic [15:0]          screen_width,
   input  logic [15:0]          screen_height,
   output trk_pkg::point_type   point
);
   import trk_pkg::*;

   always_comb begin
      case (orientation)
         ORIENT_DIRECT: begin
            point.x = first_word;
            point.y = second_word;
         end
         ORIENT_MIRROR: begin
            point.x = screen_width - first_word;
            point.y = screen_height - second_word;
         end
         ORIENT_SWAP_YM: begin
            point.x = second_word;
            point.y = screen_height - first_word;
         end
         default: begin
            point.x = screen_width - second_word;
            point.y = first_word;
         end
      endcase
   end

endmodule

### hdl/trk_merge.sv
// ----------------------------------------------------------------------------
// Touch report tracker merge stage
// Combines the lane results with the stored state: valid mask, point 0
// recovery and press/release tracking.
// ----------------------------------------------------------------------------
module trk_merge (
   input  logic                                      sampled,
   input  logic [7:0]                                status_byte,
   input  logic [7:0]                                cur_mask,
   input  trk_pkg::point_type [trk_pkg::SLOTS-1:0]   cur_pts,
   input  trk_pkg::point_type [trk_pkg::SLOTS-1:0]   lane_pts,
   input  logic [15:0]                               screen_width,
   input  logic [15:0]                               screen_height,
   output trk_pkg::point_type [trk_pkg::SLOTS-1:0]   next_pts,
   output trk_pkg::merge_ctl_type                    ctl
);
   import trk_pkg::*;

   logic [3:0] count;
   logic       count_ok;
   logic       take;
   logic       out_of_screen;
   logic       release_chk;
   logic [7:0] low_mask;
   logic [7:0] take_mask;
   logic [7:0] mask_mid;

   assign count    = status_byte[3:0];
   assign count_ok = (count <= 4'(MAX_POINTS));
   assign take     = sampled && (count != 4'd0) && count_ok;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         low_mask[i] = (4'(i) < count);
      end
   end

   assign take_mask     = low_mask | FLAG_DOWN | FLAG_CAUGHT;
   assign out_of_screen = (lane_pts[0].x > screen_width) || (lane_pts[0].y > screen_height);

   always_comb begin
      next_pts      = cur_pts;
      mask_mid      = cur_mask;
      ctl.restart   = 1'b0;
      ctl.clear_req = sampled && status_byte[7] && count_ok;
      release_chk   = sampled && status_byte[7] && (count == 4'd0);
      if (take) begin
         // slot 4 holds the previous point 0 unless a fifth point lands there
         next_pts[SLOTS-1] = cur_pts[0];
         for (int i = 0; i < SLOTS; i++) begin
            if (take_mask[i]) begin
               next_pts[i] = lane_pts[i];
            end
         end
         mask_mid = take_mask;
         if (out_of_screen) begin
            if (count > 4'd1) begin
               next_pts[0] = lane_pts[1];
               ctl.restart = 1'b1;
            end else begin
               // single point off screen: undo point 0 and the mask, handle as ready, no points
               next_pts[0] = cur_pts[0];
               mask_mid    = cur_mask;
               release_chk = 1'b1;
            end
         end else begin
            ctl.restart = 1'b1;
         end
      end
      ctl.mask = mask_mid;
      if (release_chk) begin
         if (mask_mid[7]) begin
            ctl.mask = mask_mid & ~FLAG_DOWN;
         end else begin
            next_pts[0].x = COORD_NONE;
            next_pts[0].y = COORD_NONE;
            ctl.mask      = mask_mid & MASK_KEEP;
         end
      end
   end

endmodule

### hdl/touch_report_tracker_unit.sv
// ----------------------------------------------------------------------------
// Touch report tracker unit
// Poll gating, per-point coordinate lanes and press/release tracking for a
// five-point touch controller.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one poll item per handshake (status byte plus five raw word
//            pairs), accepted when req_valid is high and req_stall is low.
//   rsp_*  : one result item per poll: status mask, clear request and the
//            stored coordinates of all five slots after that poll.
//   csr_*  : screen width, height and orientation; write only while idle.
// The result of an item accepted at one edge is registered and valid after
// that edge. One item per cycle is sustained while rsp_stall is low; the five
// mapping lanes and the merge stage are combinational, closing the state loop.
// The result sits in an output register. While rsp_stall holds a waiting
// result, req_stall is raised and no new item is taken; once the result
// leaves, an item is accepted in the same cycle.
// Reset clears the poll counter, mask and stored points and restores the
// configuration to 240 x 320, direct orientation.
// ----------------------------------------------------------------------------
module touch_report_tracker_unit #(
   parameter int POLL_DIVIDER = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_status_byte,
   input  logic [15:0] req_first_word_0,
   input  logic [15:0] req_second_word_0,
   input  logic [15:0] req_first_word_1,
   input  logic [15:0] req_second_word_1,
   input  logic [15:0] req_first_word_2,
   input  logic [15:0] req_second_word_2,
   input  logic [15:0] req_first_word_3,
   input  logic [15:0] req_second_word_3,
   input  logic [15:0] req_first_word_4,
   input  logic [15:0] req_second_word_4,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_touch_status,
   output logic        rsp_clear_request,
   output logic [15:0] rsp_pos_x_0,
   output logic [15:0] rsp_pos_y_0,
   output logic [15:0] rsp_pos_x_1,
   output logic [15:0] rsp_pos_y_1,
   output logic [15:0] rsp_pos_x_2,
   output logic [15:0] rsp_pos_y_2,
   output logic [15:0] rsp_pos_x_3,
   output logic [15:0] rsp_pos_y_3,
   output logic [15:0] rsp_pos_x_4,
   output logic [15:0] rsp_pos_y_4
);
   import trk_pkg::*;

`include "touch_report_tracker_unit_assert.svh"

   localparam int               REM_W     = (POLL_DIVIDER > 1) ? $clog2(POLL_DIVIDER) : 1;
   localparam logic [REM_W-1:0] REM_LAST  = REM_W'(POLL_DIVIDER - 1);
   localparam logic [7:0]       DIV_COUNT = 8'(POLL_DIVIDER);

   logic [15:0]                width_ff, width_in;
   logic [15:0]                height_ff, height_in;
   orient_type                 orient_ff, orient_in;

   logic [7:0]                 poll_count_ff, poll_count_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [7:0]                 mask_ff, mask_in;
   point_type [SLOTS-1:0]      pts_ff, pts_in;
   logic                       clr_ff, clr_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       req_accept;
   logic [7:0]                 tick;
   logic                       sampled;
   logic [15:0]                first_w [SLOTS];
   logic [15:0]                second_w [SLOTS];
   point_type [SLOTS-1:0]      lane_pts;
   point_type [SLOTS-1:0]      merge_pts;
   merge_ctl_type              merge_ctl;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign first_w[0]  = req_first_word_0;
   assign second_w[0] = req_second_word_0;
   assign first_w[1]  = req_first_word_1;
   assign second_w[1] = req_second_word_1;
   assign first_w[2]  = req_first_word_2;
   assign second_w[2] = req_second_word_2;
   assign first_w[3]  = req_first_word_3;
   assign second_w[3] = req_second_word_3;
   assign first_w[4]  = req_first_word_4;
   assign second_w[4] = req_second_word_4;

   for (genvar g = 0; g < SLOTS; g++) begin : g_lane
      trk_lane u_lane (
         .first_word    (first_w[g]),
         .second_word   (second_w[g]),
         .orientation   (orient_ff),
         .screen_width  (width_ff),
         .screen_height (height_ff),
         .point         (lane_pts[g])
      );
   end

   // count never passes the wrap limit, so the increment cannot overflow;
   // rem_ff tracks poll_count modulo the divider
   assign tick    = poll_count_ff + 8'd1;
   assign sampled = (rem_ff == REM_LAST) || (tick < DIV_COUNT);

   trk_merge u_merge (
      .sampled       (sampled),
      .status_byte   (req_status_byte),
      .cur_mask      (mask_ff),
      .cur_pts       (pts_ff),
      .lane_pts      (lane_pts),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .next_pts      (merge_pts),
      .ctl           (merge_ctl)
   );

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      orient_in = orient_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            CSR_ORIENT: orient_in = orient_type'(csr_wdata[1:0]);
            default:    ;
         endcase
      end
   end

   always_comb begin
      poll_count_in = poll_count_ff;
      rem_in        = rem_ff;
      mask_in       = mask_ff;
      pts_in        = pts_ff;
      clr_in        = clr_ff;
      if (req_accept) begin
         mask_in = merge_ctl.mask;
         pts_in  = merge_pts;
         clr_in  = merge_ctl.clear_req;
         if (merge_ctl.restart) begin
            poll_count_in = 8'd0;
            rem_in        = '0;
         end else if (tick > WRAP_LIMIT) begin
            poll_count_in = DIV_COUNT;
            rem_in        = '0;
         end else begin
            poll_count_in = tick;
            rem_in        = (rem_ff == REM_LAST) ? '0 : rem_ff + 1'b1;
         end
      end
      rsp_valid_in = req_accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         orient_ff     <= ORIENT_DIRECT;
         poll_count_ff <= 8'd0;
         rem_ff        <= '0;
         mask_ff       <= 8'd0;
         pts_ff        <= '0;
         clr_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         orient_ff     <= orient_in;
         poll_count_ff <= poll_count_in;
         rem_ff        <= rem_in;
         mask_ff       <= mask_in;
         pts_ff        <= pts_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_touch_status  = mask_ff;
   assign rsp_clear_request = clr_ff;
   assign rsp_pos_x_0       = pts_ff[0].x;
   assign rsp_pos_y_0       = pts_ff[0].y;
   assign rsp_pos_x_1       = pts_ff[1].x;
   assign rsp_pos_y_1       = pts_ff[1].y;
   assign rsp_pos_x_2       = pts_ff[2].x;
   assign rsp_pos_y_2       = pts_ff[2].y;
   assign rsp_pos_x_3       = pts_ff[3].x;
   assign rsp_pos_y_3       = pts_ff[3].y;
   assign rsp_pos_x_4       = pts_ff[4].x;
   assign rsp_pos_y_4       = pts_ff[4].y;

   `TRK_ASSERT_NOW(a_count_range, clock, reset, 1'b1, poll_count_ff <= WRAP_LIMIT)
   `TRK_ASSERT_NOW(a_rem_zero, clock, reset, poll_count_ff == 8'd0, rem_ff == '0)
   `TRK_ASSERT_NOW(a_hold_blocks, clock, reset, rsp_valid_ff && rsp_stall, !req_accept)
   `TRK_ASSERT_NEXT(a_result_follows, clock, reset, req_accept, rsp_valid_ff)
   `TRK_ASSERT_NEXT(a_clear_needs_ready, clock, reset, req_accept && !req_status_byte[7],
                    !clr_ff)

endmodule
